FILE: hw/rtl/dmac_pkg.sv
// Shared types and constants of the direct-mapped address cache.
// No dependencies.
package dmac_pkg;

    localparam int KEY_W = 64;
    localparam int UW_W = 3;
    localparam int DATA_W = 64;
    localparam int KIND_W = 2;

    localparam int DEF_TABLE_SIZE = 1024;

    // Key bits folded into the slot remainder per cycle (non power-of-two tables).
    localparam int SLOT_BITS_PER_CYCLE = 4;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RANGE  = 2'd3;

    typedef struct packed {
        logic [UW_W-1:0]   unwinder;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } entry_data_t;

endpackage

FILE: hw/rtl/direct_mapped_address_cache_top.sv
// Direct-mapped address cache: control sequencer, key RAM and entry data RAM.
// Uses dmac_pkg, dmac_slot_unit and dmac_ram.
// Insert finishes once the slot index is ready; lookup and delete add a check of
// the registered key and data RAM reads. A non power-of-two TABLE_SIZE adds the
// radix-16 slot remainder. Delete range reads one key RAM entry per cycle. One transfer at
// a time: busy stays high until done. The receiver
// cannot stall. After reset a clearing pass over every table entry holds busy high.
module direct_mapped_address_cache_top #(
    parameter int TABLE_SIZE = dmac_pkg::DEF_TABLE_SIZE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dmac_pkg::KIND_W-1:0]   kind,
    input  logic [dmac_pkg::KEY_W-1:0]    key,
    input  logic [dmac_pkg::KEY_W-1:0]    range_end,
    input  logic [dmac_pkg::UW_W-1:0]     unwinder_id,
    input  logic [dmac_pkg::DATA_W-1:0]   first_payload,
    input  logic [dmac_pkg::DATA_W-1:0]   second_payload,
    output logic                          done,
    output logic                          hit,
    output logic [dmac_pkg::DATA_W-1:0]   found_first_payload,
    output logic [dmac_pkg::DATA_W-1:0]   found_second_payload
);

    import dmac_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SLOT   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_RANGE  = 3'd4;
    localparam logic [2:0] S_RDRAIN = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic              pend_reg, pend_next;

    logic [KIND_W-1:0] kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  end_reg;
    logic [UW_W-1:0]   uw_reg;
    logic [DATA_W-1:0] p1_reg;
    logic [DATA_W-1:0] p2_reg;

    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [DATA_W-1:0] f1_reg, f1_next;
    logic [DATA_W-1:0] f2_reg, f2_next;

    logic              accept;
    logic              slot_valid;
    logic [IDX_W-1:0]  slot;

    logic              key_we;
    logic [IDX_W-1:0]  key_waddr;
    logic [KEY_W-1:0]  key_wdata;
    logic [IDX_W-1:0]  key_raddr;
    logic [KEY_W-1:0]  key_rdata;

    logic              data_we;
    entry_data_t       data_wdata;
    entry_data_t       data_rdata;

    logic              in_range;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign done                 = done_reg;
    assign hit                  = hit_reg;
    assign found_first_payload  = f1_reg;
    assign found_second_payload = f2_reg;

    assign in_range = (key_rdata >= key_reg) && (key_rdata < end_reg);

    dmac_slot_unit #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_slot (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && (kind != KIND_RANGE)),
        .key        (key),
        .slot_valid (slot_valid),
        .slot       (slot)
    );

    dmac_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    dmac_ram #(
        .WIDTH  ($bits(entry_data_t)),
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr ((state_reg == S_CLEAR) ? cnt_reg : slot),
        .wdata (data_wdata),
        .raddr (slot),
        .rdata (data_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        widx_next  = widx_reg;
        pend_next  = pend_reg;
        done_next  = 1'b0;
        hit_next   = 1'b0;
        f1_next    = '0;
        f2_next    = '0;
        key_we     = 1'b0;
        key_waddr  = slot;
        key_wdata  = '0;
        key_raddr  = slot;
        data_we    = 1'b0;
        data_wdata = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                key_we    = 1'b1;
                key_waddr = cnt_reg;
                data_we   = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_RANGE)
                    begin
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_RANGE;
                    end
                    else
                    begin
                        state_next = S_SLOT;
                    end
                end
            end
            S_SLOT:
            begin
                if (slot_valid)
                begin
                    if (kind_reg == KIND_INSERT)
                    begin
                        key_we     = 1'b1;
                        key_wdata  = key_reg;
                        data_we    = 1'b1;
                        data_wdata = '{unwinder: uw_reg, first: p1_reg, second: p2_reg};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (kind_reg == KIND_LOOKUP)
                begin
                    if ((key_rdata == key_reg) && (data_rdata.unwinder == uw_reg))
                    begin
                        hit_next = 1'b1;
                        f1_next  = data_rdata.first;
                        f2_next  = data_rdata.second;
                    end
                end
                else
                begin
                    key_we = (key_rdata == key_reg);
                end
            end
            S_RANGE:
            begin
                key_raddr = cnt_reg;
                pend_next = 1'b1;
                widx_next = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                key_waddr = widx_reg;
                key_we    = pend_reg && in_range;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_RDRAIN;
                end
            end
            S_RDRAIN:
            begin
                key_waddr  = widx_reg;
                key_we     = in_range;
                pend_next  = 1'b0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            widx_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            widx_reg  <= widx_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        f1_reg  <= f1_next;
        f2_reg  <= f2_next;
        if (accept)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            end_reg  <= range_end;
            uw_reg   <= unwinder_id;
            p1_reg   <= first_payload;
            p2_reg   <= second_payload;
        end
    end

endmodule

FILE: hw/rtl/dmac_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Depends on nothing.
module dmac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/dmac_slot_unit.sv
// Slot index unit: key modulo TABLE_SIZE. Masks for power-of-two sizes,
// otherwise a radix-16 restoring remainder, one key digit per step. Uses dmac_pkg.
module dmac_slot_unit #(
    parameter int TABLE_SIZE = 1024,
    parameter int IDX_W = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [dmac_pkg::KEY_W-1:0] key,
    output logic                     slot_valid,
    output logic [IDX_W-1:0]         slot
);

    import dmac_pkg::*;

    localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    logic valid_reg;

    assign slot_valid = valid_reg;

    generate
        if (IS_POW2)
        begin : g_mask
            logic [IDX_W-1:0] slot_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg <= 1'b0;
                end
                else
                begin
                    valid_reg <= load;
                end
            end

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    slot_reg <= IDX_W'(key & KEY_W'(TABLE_SIZE - 1));
                end
            end

            assign slot = slot_reg;
        end
        else
        begin : g_rem
            localparam int RW = IDX_W + 1;
            localparam int STEPS = KEY_W / SLOT_BITS_PER_CYCLE;
            localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

            logic              run_reg;
            logic [STEP_W-1:0] step_reg;
            logic [KEY_W-1:0]  shift_reg;
            logic [RW-1:0]     rem_reg;
            logic [RW-1:0]     rem_next;

            always_comb
            begin
                logic [RW-1:0] r;
                r = rem_reg;
                for (int j = 0; j < SLOT_BITS_PER_CYCLE; j++)
                begin
                    r = {r[RW-2:0], shift_reg[KEY_W-1-j]};
                    if (r >= RW'(TABLE_SIZE))
                    begin
                        r = r - RW'(TABLE_SIZE);
                    end
                end
                rem_next = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_reg   <= 1'b0;
                    valid_reg <= 1'b0;
                    step_reg  <= '0;
                end
                else
                begin
                    valid_reg <= 1'b0;
                    if (load)
                    begin
                        run_reg  <= 1'b1;
                        step_reg <= '0;
                    end
                    else if (run_reg)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == STEP_W'(STEPS - 1))
                        begin
                            run_reg   <= 1'b0;
                            valid_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    shift_reg <= key;
                    rem_reg   <= '0;
                end
                else if (run_reg)
                begin
                    shift_reg <= shift_reg << SLOT_BITS_PER_CYCLE;
                    rem_reg   <= rem_next;
                end
            end

            assign slot = rem_reg[IDX_W-1:0];
        end
    endgenerate

endmodule

FILE: sim/direct_mapped_address_cache_top_tb.sv
// Self-checking testbench for direct_mapped_address_cache_top: directed and random
// insert, lookup, delete and range delete checked against a table mirror.
// Depends on dmac_pkg and the cache RTL.
module direct_mapped_address_cache_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dmac_pkg::*;

    localparam int SLOTS = DEF_TABLE_SIZE;
    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 32;
    localparam logic [KEY_W-1:0] ALL_ONES = '1;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  lim;
        logic [UW_W-1:0]   uw;
        logic [DATA_W-1:0] p1;
        logic [DATA_W-1:0] p2;
        int                gap;
        bit                drain;
    } cache_op_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } reply_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [UW_W-1:0]  uw;
    } known_key_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [KIND_W-1:0] kind = KIND_LOOKUP;
    logic [KEY_W-1:0]  key = '0;
    logic [KEY_W-1:0]  range_end = '0;
    logic [UW_W-1:0]   unwinder_id = '0;
    logic [DATA_W-1:0] first_payload = '0;
    logic [DATA_W-1:0] second_payload = '0;
    logic              busy;
    logic              done;
    logic              hit;
    logic [DATA_W-1:0] found_first_payload;
    logic [DATA_W-1:0] found_second_payload;

    cache_op_t  op_backlog[$];
    reply_t     pending_replies[$];
    known_key_t key_pool[$];

    logic [KEY_W-1:0]  mirror_key[SLOTS];
    logic [UW_W-1:0]   mirror_uw[SLOTS];
    logic [DATA_W-1:0] mirror_first[SLOTS];
    logic [DATA_W-1:0] mirror_second[SLOTS];

    int     wait_cnt = 0;
    int     idle_cycles = 0;
    int     fail_cnt = 0;
    int     issued_cnt = 0;
    int     checked_cnt = 0;
    int     hit_cnt = 0;
    int     kind_cnt[4] = '{0, 0, 0, 0};
    bit     burst = 1'b0;
    bit     hold_next = 1'b0;
    reply_t oldest;

    direct_mapped_address_cache_top dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .kind                 (kind),
        .key                  (key),
        .range_end            (range_end),
        .unwinder_id          (unwinder_id),
        .first_payload        (first_payload),
        .second_payload       (second_payload),
        .done                 (done),
        .hit                  (hit),
        .found_first_payload  (found_first_payload),
        .found_second_payload (found_second_payload)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Applies one operation to the mirror and returns the reply it produces.
    function automatic reply_t table_access(cache_op_t op);
        reply_t r;
        int     idx;
        r = '{kind: op.kind, hit: 1'b0, first: '0, second: '0};
        idx = int'(op.key % 64'(SLOTS));
        case (op.kind)
            KIND_INSERT:
            begin
                mirror_key[idx] = op.key;
                mirror_uw[idx] = op.uw;
                mirror_first[idx] = op.p1;
                mirror_second[idx] = op.p2;
            end
            KIND_LOOKUP:
            begin
                if (mirror_key[idx] == op.key && mirror_uw[idx] == op.uw)
                begin
                    r.hit = 1'b1;
                    r.first = mirror_first[idx];
                    r.second = mirror_second[idx];
                end
            end
            KIND_DELETE:
            begin
                if (mirror_key[idx] == op.key)
                    mirror_key[idx] = '0;
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (mirror_key[i] >= op.key && mirror_key[i] < op.lim)
                        mirror_key[i] = '0;
            end
        endcase
        return r;
    endfunction

    task automatic queue_op(logic [KIND_W-1:0] k, logic [KEY_W-1:0] a, logic [KEY_W-1:0] lim,
                            logic [UW_W-1:0] uw, logic [DATA_W-1:0] p1,
                            logic [DATA_W-1:0] p2);
        cache_op_t op;
        op = '{kind: k, key: a, lim: lim, uw: uw, p1: p1, p2: p2,
               gap: burst ? 0 : int'($urandom_range(8)), drain: hold_next};
        op_backlog.push_back(op);
        if (k == KIND_INSERT)
        begin
            key_pool.push_back('{key: a, uw: uw});
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic send_next();
        cache_op_t op;
        op = op_backlog.pop_front();
        start <= 1'b1;
        kind <= op.kind;
        key <= op.key;
        range_end <= op.lim;
        unwinder_id <= op.uw;
        first_payload <= op.p1;
        second_payload <= op.p2;
        wait_cnt = 0;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                issued_cnt++;
                kind_cnt[kind]++;
                pending_replies.push_back(table_access('{kind: kind, key: key, lim: range_end,
                    uw: unwinder_id, p1: first_payload, p2: second_payload, gap: 0,
                    drain: 1'b0}));
                if (op_backlog.size() != 0 && op_backlog[0].gap == 0 && !op_backlog[0].drain)
                    send_next();
                else
                begin
                    start <= 1'b0;
                    wait_cnt = 0;
                end
            end
            else if (!start && op_backlog.size() != 0)
            begin
                if (wait_cnt < op_backlog[0].gap)
                    wait_cnt++;
                else if (!op_backlog[0].drain || pending_replies.size() == 0)
                    send_next();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected transfer: hit=%0b first=%h second=%h",
                             hit, found_first_payload, found_second_payload);
            end
            else
            begin
                oldest = pending_replies.pop_front();
                checked_cnt++;
                if (hit === 1'b1)
                    hit_cnt++;
                if (hit !== oldest.hit || found_first_payload !== oldest.first
                        || found_second_payload !== oldest.second)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch on transfer %0d (kind %0d): exp hit=%0b %h %h, got hit=%0b %h %h",
                                 checked_cnt, oldest.kind, oldest.hit, oldest.first,
                                 oldest.second, hit, found_first_payload,
                                 found_second_payload);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d cycles without a transfer", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        known_key_t       pk;
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        logic [KEY_W-1:0] alias_key;
        logic [UW_W-1:0]  uw;
        logic [DATA_W-1:0] p1;
        logic [DATA_W-1:0] p2;
        int               sel;
        int               r2;

        foreach (mirror_key[i])
        begin
            mirror_key[i] = '0;
            mirror_uw[i] = '0;
            mirror_first[i] = '0;
            mirror_second[i] = '0;
        end

        // directed: key zero on an empty table, id mismatch, aliasing, stale payloads,
        // inverted, empty, partial and full ranges
        queue_op(KIND_LOOKUP, '0, '0, 3'd0, '0, '0);
        queue_op(KIND_LOOKUP, '0, ALL_ONES, 3'd5, ALL_ONES, ALL_ONES);
        queue_op(KIND_INSERT, ALL_ONES, '0, 3'd7, ALL_ONES, ALL_ONES);
        queue_op(KIND_LOOKUP, ALL_ONES, '0, 3'd7, '0, '0);
        queue_op(KIND_LOOKUP, ALL_ONES, '0, 3'd6, '0, '0);
        queue_op(KIND_LOOKUP, ALL_ONES - 64'(SLOTS), '0, 3'd7, '0, '0);
        queue_op(KIND_DELETE, ALL_ONES - 64'(SLOTS), '0, 3'd7, '0, '0);
        queue_op(KIND_LOOKUP, ALL_ONES, '0, 3'd7, '0, '0);
        queue_op(KIND_DELETE, ALL_ONES, '0, 3'd0, '0, '0);
        queue_op(KIND_LOOKUP, ALL_ONES, '0, 3'd7, '0, '0);
        queue_op(KIND_INSERT, 64'(SLOTS), '0, 3'd3, 64'hA5A5_A5A5_A5A5_A5A5,
                 64'h5A5A_5A5A_5A5A_5A5A);
        queue_op(KIND_DELETE, 64'(SLOTS), '0, 3'd0, '0, '0);
        queue_op(KIND_LOOKUP, '0, '0, 3'd3, '0, '0);
        queue_op(KIND_INSERT, 64'd5, '0, 3'd1, 64'd11, 64'd12);
        queue_op(KIND_INSERT, 64'd2000, '0, 3'd2, 64'd21, 64'd22);
        queue_op(KIND_INSERT, 64'h8000_0000_0000_0000, '0, 3'd4, 64'd31, 64'd32);
        queue_op(KIND_RANGE, 64'd2000, 64'd5, 3'd0, '0, '0);
        queue_op(KIND_RANGE, 64'd5, 64'd5, 3'd0, '0, '0);
        queue_op(KIND_LOOKUP, 64'd5, '0, 3'd1, '0, '0);
        queue_op(KIND_RANGE, 64'd5, 64'd2000, 3'd0, '0, '0);
        queue_op(KIND_LOOKUP, 64'd5, '0, 3'd1, '0, '0);
        queue_op(KIND_LOOKUP, 64'd2000, '0, 3'd2, '0, '0);
        queue_op(KIND_RANGE, '0, ALL_ONES, 3'd0, '0, '0);
        queue_op(KIND_LOOKUP, 64'd2000, '0, 3'd2, '0, '0);
        queue_op(KIND_LOOKUP, 64'h8000_0000_0000_0000, '0, 3'd4, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                burst = ($urandom_range(2) == 0);
            hold_next = (n % 400 == 0) || ($urandom_range(199) == 0);
            if (key_pool.size() != 0)
                pk = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                pk = '{key: rand64(), uw: 3'($urandom_range(7))};
            alias_key = pk.key + 64'(SLOTS) * 64'($urandom_range(1, 9));
            a = rand64();
            b = rand64();
            uw = 3'($urandom_range(7));
            p1 = rand64();
            p2 = rand64();
            if ($urandom_range(19) == 0)
                p1 = $urandom_range(1) ? ALL_ONES : '0;
            if ($urandom_range(19) == 0)
                p2 = $urandom_range(1) ? ALL_ONES : '0;
            sel = $urandom_range(99);
            r2 = $urandom_range(99);
            if (sel < 35)
            begin
                if (r2 < 45)
                    ;
                else if (r2 < 70)
                    a = 64'($urandom_range(4095));
                else if (r2 < 85)
                    a = alias_key;
                else if (r2 < 92)
                    a = ALL_ONES - 64'($urandom_range(2047));
                else
                    a = pk.key;
                queue_op(KIND_INSERT, a, b, uw, p1, p2);
            end
            else if (sel < 75)
            begin
                if (r2 < 65)
                    a = pk.key;
                else if (r2 < 80)
                    a = alias_key;
                else if (r2 < 90)
                    a = 64'($urandom_range(4095));
                if ($urandom_range(4) != 0)
                    uw = pk.uw;
                queue_op(KIND_LOOKUP, a, b, uw, p1, p2);
            end
            else if (sel < 92)
            begin
                if (r2 < 60)
                    a = pk.key;
                else if (r2 < 80)
                    a = alias_key;
                else
                    a = 64'($urandom_range(4095));
                queue_op(KIND_DELETE, a, b, uw, p1, p2);
            end
            else
            begin
                if (r2 < 60)
                begin
                    a = pk.key - 64'($urandom_range(32));
                    b = pk.key + 64'($urandom_range(1, 4096));
                end
                else if (r2 < 80)
                begin
                    b = pk.key;
                    a = $urandom_range(1) ? pk.key : pk.key + 64'($urandom_range(1, 64));
                end
                else if (r2 < 95)
                    ;
                else
                begin
                    a = '0;
                    b = $urandom_range(1) ? ALL_ONES : 64'($urandom_range(4096));
                end
                queue_op(KIND_RANGE, a, b, uw, p1, p2);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || start)
            @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d transfers issued: %0d inserts, %0d lookups, %0d deletes, %0d range deletes",
                 issued_cnt, kind_cnt[KIND_INSERT], kind_cnt[KIND_LOOKUP],
                 kind_cnt[KIND_DELETE], kind_cnt[KIND_RANGE]);
        $display("%0d replies checked, %0d lookup hits, %0d failures",
                 checked_cnt, hit_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
